@@ src/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator: command and
// status codes, table entry layout, sequencer states and register map.
// ----------------------------------------------------------------------------
package ffba_pkg;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_REALLOC = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_ALLOC,
      S_APPEND,
      S_FREE_OLD
   } state_type;

   // one word of the block table
   typedef struct packed {
      logic [31:0] blk_start;
      logic [23:0] blk_size;
      logic        blk_free;
   } entry_type;

   typedef struct packed {
      logic [31:0] result_address;
      status_type  status;
      logic [31:0] copy_source;
      logic [23:0] copy_length;
   } rsp_type;

   localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
   localparam logic [1:0] REG_HEAP_LIMIT   = 2'd1;
   localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

   localparam logic [31:0] HEAP_BASE_RST    = 32'd65536;
   localparam logic [31:0] HEAP_LIMIT_RST   = 32'd1048576;
   localparam logic [6:0]  HEADER_BYTES_RST = 7'd24;

endpackage

@@ src/first_fit_block_allocator.sv @@
// Size-zero allocates, frees of address zero and unused commands answer from idle
// without a scan. Free/realloc lookup scans the table, one entry per cycle
// through the table RAM read port; allocate scans for a first fit, then appends,
// and a realloc that must move also frees its old entry.
// A new command is taken in the cycle its predecessor's result strobe is shown.
// Reset (synchronous): table empty, heap_top = heap_base, registers at defaults.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Heap block table in a two-port RAM, scanned in address order by a small
// sequencer for first-fit reuse, address lookup and bump-pointer append.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [23:0] req_request_size,
   input  logic [31:0] req_block_address,
   // result channel
   output logic        rsp_valid,
   output logic [31:0] rsp_result_address,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_copy_source,
   output logic [23:0] rsp_copy_length,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

   // registers
   logic [31:0]      heap_base_ff, heap_base_in;
   logic [31:0]      heap_limit_ff, heap_limit_in;
   logic [6:0]       header_bytes_ff, header_bytes_in;
   logic [31:0]      heap_top_ff, heap_top_in;
   logic [CNT_W-1:0] count_ff, count_in;
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;

   // latched command
   logic [23:0]      size_ff, size_in;
   logic [31:0]      addr_ff, addr_in;
   logic             free_op_ff, free_op_in;
   logic             moving_ff, moving_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [31:0]      old_start_ff, old_start_in;
   logic [23:0]      old_size_ff, old_size_in;
   logic [31:0]      new_addr_ff, new_addr_in;

   logic             rsp_valid_ff, rsp_fire;
   rsp_type          rsp_ff, rsp_in;

   // table RAM
   entry_type        entry_ram [MAX_BLOCKS];
   entry_type        rd_data_ff;
   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_ra, mem_wa;
   entry_type        mem_wd;

   logic             cfg_we;
   logic             scan_valid, addr_match, fits, append_ok;
   logic             alloc_done;
   logic [31:0]      alloc_addr;
   logic [31:0]      payload_addr;
   logic [32:0]      append_end;
   logic [CNT_W-1:0] next_idx;

   assign cfg_we = psel && penable && pwrite;
   assign pready = 1'b1;
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      unique case (paddr[3:2])
         REG_HEAP_BASE:    prdata = heap_base_ff;
         REG_HEAP_LIMIT:   prdata = heap_limit_ff;
         REG_HEADER_BYTES: prdata = {25'd0, header_bytes_ff};
         default:          prdata = 32'd0;
      endcase
   end

   always_comb begin
      heap_base_in    = heap_base_ff;
      heap_limit_in   = heap_limit_ff;
      header_bytes_in = header_bytes_ff;
      if (cfg_we) begin
         unique case (paddr[3:2])
            REG_HEAP_BASE:    heap_base_in    = pwdata;
            REG_HEAP_LIMIT:   heap_limit_in   = pwdata;
            REG_HEADER_BYTES: header_bytes_in = pwdata[6:0];
            default:          ;
         endcase
      end
   end

   assign scan_valid   = (scan_idx_ff < count_ff);
   assign addr_match   = (({1'b0, rd_data_ff.blk_start} + 33'(header_bytes_ff))
                          == {1'b0, addr_ff});
   assign fits         = (rd_data_ff.blk_size >= size_ff);
   assign payload_addr = rd_data_ff.blk_start + 32'(header_bytes_ff);
   assign append_end   = {1'b0, heap_top_ff} + 33'(header_bytes_ff) + 33'(size_ff);
   assign append_ok    = (count_ff != MAX_CNT) && (append_end <= {1'b0, heap_limit_ff});
   assign next_idx     = scan_idx_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      count_in     = count_ff;
      heap_top_in  = heap_top_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      free_op_in   = free_op_ff;
      moving_in    = moving_ff;
      old_idx_in   = old_idx_ff;
      old_start_in = old_start_ff;
      old_size_in  = old_size_ff;
      new_addr_in  = new_addr_ff;
      mem_re       = 1'b0;
      mem_ra       = next_idx[IDX_W-1:0];
      mem_we       = 1'b0;
      mem_wa       = scan_idx_ff[IDX_W-1:0];
      mem_wd       = rd_data_ff;
      rsp_fire     = 1'b0;
      rsp_in       = '0;
      alloc_done   = 1'b0;
      alloc_addr   = 32'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               size_in     = req_request_size;
               addr_in     = req_block_address;
               free_op_in  = (req_cmd == CMD_FREE);
               moving_in   = (req_cmd == CMD_REALLOC) && (req_block_address != 32'd0);
               scan_idx_in = '0;
               mem_ra      = '0;
               mem_re      = (count_ff != '0);
               unique case (req_cmd) inside
                  CMD_ALLOC, CMD_REALLOC: begin
                     if (req_block_address != 32'd0 && req_cmd == CMD_REALLOC) begin
                        state_in = S_FIND;
                     end else if (req_request_size == 24'd0) begin
                        rsp_fire      = 1'b1;
                        rsp_in.status = ST_ZERO;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  CMD_FREE: begin
                     if (req_block_address == 32'd0) begin
                        rsp_fire = 1'b1;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  default: rsp_fire = 1'b1;
               endcase
            end
         end

         S_FIND: begin
            if (!scan_valid) begin
               rsp_fire      = 1'b1;
               rsp_in.status = ST_UNKNOWN;
               state_in      = S_IDLE;
            end else if (addr_match) begin
               old_idx_in   = scan_idx_ff[IDX_W-1:0];
               old_start_in = rd_data_ff.blk_start;
               old_size_in  = rd_data_ff.blk_size;
               if (free_op_ff) begin
                  mem_we          = 1'b1;
                  mem_wd.blk_free = 1'b1;
                  rsp_fire        = 1'b1;
                  state_in        = S_IDLE;
               end else if (fits) begin
                  rsp_fire              = 1'b1;
                  rsp_in.result_address = addr_ff;
                  state_in              = S_IDLE;
               end else begin
                  // block too small: restart the scan for a first fit
                  scan_idx_in = '0;
                  mem_ra      = '0;
                  mem_re      = 1'b1;
                  state_in    = S_ALLOC;
               end
            end else begin
               scan_idx_in = next_idx;
               mem_re      = (next_idx < count_ff);
            end
         end

         S_ALLOC: begin
            if (!scan_valid) begin
               state_in = S_APPEND;
            end else if (rd_data_ff.blk_free && fits) begin
               mem_we          = 1'b1;
               mem_wd.blk_free = 1'b0;
               alloc_done      = 1'b1;
               alloc_addr      = payload_addr;
            end else begin
               scan_idx_in = next_idx;
               mem_re      = (next_idx < count_ff);
            end
         end

         S_APPEND: begin
            if (append_ok) begin
               mem_we      = 1'b1;
               mem_wa      = count_ff[IDX_W-1:0];
               mem_wd      = '{blk_start: heap_top_ff, blk_size: size_ff, blk_free: 1'b0};
               count_in    = count_ff + CNT_W'(1);
               heap_top_in = append_end[31:0];
               alloc_done  = 1'b1;
               alloc_addr  = heap_top_ff + 32'(header_bytes_ff);
            end else begin
               rsp_fire      = 1'b1;
               rsp_in.status = ST_FULL;
               state_in      = S_IDLE;
            end
         end

         S_FREE_OLD: begin
            mem_we                = 1'b1;
            mem_wa                = old_idx_ff;
            mem_wd                = '{blk_start: old_start_ff, blk_size: old_size_ff,
                                      blk_free: 1'b1};
            rsp_fire              = 1'b1;
            rsp_in.result_address = new_addr_ff;
            rsp_in.copy_source    = addr_ff;
            rsp_in.copy_length    = old_size_ff;
            state_in              = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      if (alloc_done) begin
         if (moving_ff) begin
            new_addr_in = alloc_addr;
            state_in    = S_FREE_OLD;
         end else begin
            rsp_fire              = 1'b1;
            rsp_in.result_address = alloc_addr;
            state_in              = S_IDLE;
         end
      end

      // heap_top tracks heap_base while the table is empty
      if (cfg_we && paddr[3:2] == REG_HEAP_BASE && count_ff == '0) begin
         heap_top_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         heap_top_ff     <= HEAP_BASE_RST;
         heap_base_ff    <= HEAP_BASE_RST;
         heap_limit_ff   <= HEAP_LIMIT_RST;
         header_bytes_ff <= HEADER_BYTES_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         heap_top_ff     <= heap_top_in;
         heap_base_ff    <= heap_base_in;
         heap_limit_ff   <= heap_limit_in;
         header_bytes_ff <= header_bytes_in;
         rsp_valid_ff    <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      free_op_ff   <= free_op_in;
      moving_ff    <= moving_in;
      old_idx_ff   <= old_idx_in;
      old_start_ff <= old_start_in;
      old_size_ff  <= old_size_in;
      new_addr_ff  <= new_addr_in;
      if (rsp_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_ram[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= entry_ram[mem_ra];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_ff.result_address;
   assign rsp_status         = rsp_ff.status;
   assign rsp_copy_source    = rsp_ff.copy_source;
   assign rsp_copy_length    = rsp_ff.copy_length;

endmodule

@@ src/ffba_checker.sv @@
// ----------------------------------------------------------------------------
// ffba_port_checks
// Port-level checks on the allocator's command/result sequencing.
// ----------------------------------------------------------------------------
module ffba_port_checks
   import ffba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_result_address,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_copy_source,
   input logic [23:0] rsp_copy_length
);

   // an accepted beat either answers at once or holds the port busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither answered nor busy");

   // leaving busy always delivers the result beat
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_result_address == 32'd0 && rsp_copy_source == 32'd0 &&
       rsp_copy_length == 24'd0))
      else $error("failed command carries a nonzero field");

   a_copy_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_copy_length != 24'd0) |->
      (rsp_status == ST_OK && rsp_copy_source != 32'd0))
      else $error("copy reported without a successful move");

endmodule

bind first_fit_block_allocator ffba_port_checks u_ffba_checker (.*);
